// ===== rtl/core/rqf_pkg.sv =====
// shared types and constants for the ready queue with remove-by-id
// no dependencies; imported by every module of the block
package rqf_pkg;

    localparam int unsigned MAX_PROCS_DEF = 64;

    localparam int KIND_W   = 2;
    localparam int PID_W    = 7;
    localparam int ID_OUT_W = 7;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W = 3;

    localparam logic [ID_OUT_W-1:0] NO_ID = 7'h7F;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_REM  = 2'd1,
        KIND_POP  = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic capture;
        logic enq;
        logic pop;
        logic rem;
    } cell_ctl_t;

endpackage

// ===== rtl/core/rqf_cell.sv =====
// one queue slot: stored id, occupancy bit and registered match flag
// depends on rqf_pkg
module rqf_cell #(
    parameter int ID_W = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rqf_pkg::cell_ctl_t ctl,
    input  logic [ID_W-1:0]    pid,
    input  logic               prev_used,
    input  logic [ID_W-1:0]    next_id,
    input  logic               next_used,
    input  logic               hit_upto,
    output logic [ID_W-1:0]    id,
    output logic               used,
    output logic               match
);
    import rqf_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            used_reg;
    logic            used_next;
    logic            match_reg;
    logic            match_next;
    logic            shift;
    logic            load;

    always_comb
    begin
        // close up toward the head, or take the new word at the tail
        shift      = ctl.pop || (ctl.rem && hit_upto);
        load       = ctl.enq && !used_reg && prev_used;
        id_next    = id_reg;
        used_next  = used_reg;
        if (shift)
        begin
            id_next   = next_id;
            used_next = next_used;
        end
        else if (load)
        begin
            id_next   = pid;
            used_next = 1'b1;
        end
        match_next = ctl.capture ? (used_reg && (id_reg == pid)) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            match_reg <= match_next;
        end
    end

    assign id    = id_reg;
    assign used  = used_reg;
    assign match = match_reg;

endmodule

// ===== rtl/core/rqf_prefix.sv =====
// inclusive prefix or over the cell match flags, log-depth
// depends on rqf_pkg
module rqf_prefix #(
    parameter int N = 64
) (
    input  logic [N-1:0] hit,
    output logic [N-1:0] hit_upto,
    output logic         found
);
    import rqf_pkg::*;

    localparam int LV = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] lvl [0:LV];

    always_comb
    begin
        lvl[0] = hit;
        for (int k = 0; k < LV; k++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i >= (1 << k))
                begin
                    lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
                end
                else
                begin
                    lvl[k+1][i] = lvl[k][i];
                end
            end
        end
    end

    assign hit_upto = lvl[LV];
    assign found    = lvl[LV][N-1];

endmodule

// ===== rtl/core/ready_queue_fifo_remove_by_id.sv =====
// ready queue of process ids: enqueue, remove first match, pop head
// depends on rqf_pkg, rqf_cell, rqf_prefix
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid, in_ready, kind, proc_id              | in
//   out     | out_valid, out_ready, popped_id, head_id,      | out
//           | entry_count, high_water, status                |
//
// for each word the cells compare their ids in the accept cycle, then
// the prefix of matches picks the shift and the row updates while the
// result is registered. a held result stalls only the update cycle; the
// next word is taken as soon as the sequencer is back in idle.
// reset empties the queue and clears the high-water mark at once.
module ready_queue_fifo_remove_by_id #(
    parameter int MAX_PROCS = rqf_pkg::MAX_PROCS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rqf_pkg::KIND_W-1:0]      kind,
    input  logic [rqf_pkg::PID_W-1:0]       proc_id,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rqf_pkg::ID_OUT_W-1:0]    popped_id,
    output logic [rqf_pkg::ID_OUT_W-1:0]    head_id,
    output logic [rqf_pkg::CNT_OUT_W-1:0]   entry_count,
    output logic [rqf_pkg::CNT_OUT_W-1:0]   high_water,
    output logic [rqf_pkg::STATUS_W-1:0]    status
);
    import rqf_pkg::*;

    localparam int N     = MAX_PROCS;
    localparam int ID_W  = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    state_t            state_reg;
    state_t            state_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [ID_W-1:0]   pid_reg;
    logic [ID_W-1:0]   pid_next;
    logic              pid_ok_reg;
    logic              pid_ok_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  peak_reg;
    logic [CNT_W-1:0]  peak_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [ID_OUT_W-1:0]   popped_reg;
    logic [ID_OUT_W-1:0]   popped_next;
    logic [ID_OUT_W-1:0]   head_reg;
    logic [ID_OUT_W-1:0]   head_next;
    logic [CNT_OUT_W-1:0]  count_out_reg;
    logic [CNT_OUT_W-1:0]  count_out_next;
    logic [CNT_OUT_W-1:0]  peak_out_reg;
    logic [CNT_OUT_W-1:0]  peak_out_next;
    status_t               status_reg;
    status_t               status_next;

    cell_ctl_t         ctl;
    logic [ID_W-1:0]   cell_pid;
    logic [ID_W-1:0]   id_arr [0:N-1];
    logic [N-1:0]      used_vec;
    logic [N-1:0]      match_vec;
    logic [N-1:0]      hit_upto;
    logic              found;
    logic              accept;
    logic              commit;
    logic              full;

    logic [ID_W+6:0]   id0_wide;
    logic [ID_W+6:0]   id1_wide;
    logic [ID_W+6:0]   pid_wide;
    logic [CNT_W+6:0]  cnt_wide;
    logic [CNT_W+6:0]  peak_wide;

    // ---------------------------------------------------------------- cells
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic            prev_used;
            logic [ID_W-1:0] next_id;
            logic            next_used;

            if (g == 0)
            begin : g_head
                assign prev_used = 1'b1;
            end
            else
            begin : g_mid
                assign prev_used = used_vec[g-1];
            end

            if (g == N - 1)
            begin : g_tail
                assign next_id   = '0;
                assign next_used = 1'b0;
            end
            else
            begin : g_body
                assign next_id   = id_arr[g+1];
                assign next_used = used_vec[g+1];
            end

            rqf_cell #(
                .ID_W (ID_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .pid       (cell_pid),
                .prev_used (prev_used),
                .next_id   (next_id),
                .next_used (next_used),
                .hit_upto  (hit_upto[g]),
                .id        (id_arr[g]),
                .used      (used_vec[g]),
                .match     (match_vec[g])
            );
        end
    endgenerate

    rqf_prefix #(
        .N (N)
    ) u_prefix (
        .hit      (match_vec),
        .hit_upto (hit_upto),
        .found    (found)
    );

    // ------------------------------------------------------------ sequencer
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign full     = (count_reg == CNT_W'(MAX_PROCS));
    assign cell_pid = (state_reg == S_IDLE) ? proc_id[ID_W-1:0] : pid_reg;

    assign id0_wide  = {7'b0, id_arr[0]};
    assign id1_wide  = {7'b0, id_arr[1]};
    assign pid_wide  = {7'b0, pid_reg};

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pid_next       = pid_reg;
        pid_ok_next    = pid_ok_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg && !out_ready;
        popped_next    = popped_reg;
        head_next      = head_reg;
        count_out_next = count_out_reg;
        peak_out_next  = peak_out_reg;
        status_next    = status_reg;
        ctl            = '0;
        cnt_wide       = '0;
        peak_wide      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.capture = 1'b1;
                    kind_next   = kind_t'(kind);
                    pid_next    = proc_id[ID_W-1:0];
                    pid_ok_next = ({1'b0, proc_id} < (PID_W + 1)'(MAX_PROCS));
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    status_next = ST_OK;
                    popped_next = NO_ID;
                    unique case (kind_reg)
                        KIND_ENQ:
                        begin
                            if (!pid_ok_reg)
                            begin
                                status_next = ST_BAD_ID;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.enq    = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (count_next > peak_reg)
                                begin
                                    peak_next = count_next;
                                end
                            end
                        end
                        KIND_REM:
                        begin
                            if (!pid_ok_reg)
                            begin
                                status_next = ST_BAD_ID;
                            end
                            else if (!found)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ctl.rem    = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.pop     = 1'b1;
                                popped_next = id0_wide[6:0];
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        KIND_NOP:
                        begin
                            status_next = ST_OK;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase

                    // head after the update
                    if (count_next == '0)
                    begin
                        head_next = NO_ID;
                    end
                    else if (ctl.pop || (ctl.rem && hit_upto[0]))
                    begin
                        head_next = id1_wide[6:0];
                    end
                    else if (ctl.enq && (count_reg == '0))
                    begin
                        head_next = pid_wide[6:0];
                    end
                    else
                    begin
                        head_next = id0_wide[6:0];
                    end

                    cnt_wide       = {7'b0, count_next};
                    peak_wide      = {7'b0, peak_next};
                    count_out_next = cnt_wide[6:0];
                    peak_out_next  = peak_wide[6:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        pid_reg       <= pid_next;
        pid_ok_reg    <= pid_ok_next;
        popped_reg    <= popped_next;
        head_reg      <= head_next;
        count_out_reg <= count_out_next;
        peak_out_reg  <= peak_out_next;
        status_reg    <= status_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign popped_id   = popped_reg;
    assign head_id     = head_reg;
    assign entry_count = count_out_reg;
    assign high_water  = peak_out_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    // occupancy bits agree with the running count
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_vec) == int'(count_reg))
        else $error("cell occupancy disagrees with count");

    // high-water mark never trails the count
    a_peak_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= count_reg)
        else $error("high-water mark below count");

    // a result appears only from the update cycle
    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == S_EXEC))
        else $error("result without update cycle");

    // a pop removes exactly one entry
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && ctl.pop) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shrink queue");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for ready_queue_fifo_remove_by_id: directed and random words
// checked against a queue-based prediction; depends on rqf_pkg and the block's rtl
module tb_top;
    import rqf_pkg::*;

    localparam int QDEPTH = MAX_PROCS_DEF;
    localparam int RANDOM_WORDS = 950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        kind_t            op;
        logic [PID_W-1:0] pid;
    } word_t;

    typedef struct packed {
        logic [ID_OUT_W-1:0]  popped;
        logic [ID_OUT_W-1:0]  head;
        logic [CNT_OUT_W-1:0] count;
        logic [CNT_OUT_W-1:0] peak;
        status_t              st;
    } queue_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    kind_t kind = KIND_ENQ;
    logic [PID_W-1:0] proc_id = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ID_OUT_W-1:0] popped_id;
    logic [ID_OUT_W-1:0] head_id;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [CNT_OUT_W-1:0] high_water;
    logic [STATUS_W-1:0] status;

    // predicted queue contents, head first
    logic [PID_W-1:0] ready_ids[$];
    int unsigned peak_depth = 0;

    word_t pending_words[$];
    queue_result_t expected_results[$];
    word_t next_word;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int unsigned rx_cycle = 0;
    int idle_cycles = 0;
    int fail_count = 0;

    ready_queue_fifo_remove_by_id dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .proc_id     (proc_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .popped_id   (popped_id),
        .head_id     (head_id),
        .entry_count (entry_count),
        .high_water  (high_water),
        .status      (status)
    );

    always #6 clk = ~clk;

    function automatic queue_result_t apply_word(kind_t op, logic [PID_W-1:0] pid);
        queue_result_t r;
        int hit;
        r.popped = NO_ID;
        r.st = ST_OK;
        hit = -1;
        case (op)
            KIND_ENQ:
            begin
                if (pid >= QDEPTH)
                    r.st = ST_BAD_ID;
                else if (ready_ids.size() >= QDEPTH)
                    r.st = ST_FULL;
                else
                begin
                    ready_ids.push_back(pid);
                    if (ready_ids.size() > peak_depth)
                        peak_depth = ready_ids.size();
                end
            end
            KIND_REM:
            begin
                if (pid >= QDEPTH)
                    r.st = ST_BAD_ID;
                else
                begin
                    // first match counted from the head
                    for (int i = 0; i < ready_ids.size() && hit < 0; i++)
                        if (ready_ids[i] == pid)
                            hit = i;
                    if (hit >= 0)
                        ready_ids.delete(hit);
                    else
                        r.st = ST_NOT_FOUND;
                end
            end
            KIND_POP:
            begin
                if (ready_ids.size() == 0)
                    r.st = ST_EMPTY;
                else
                    r.popped = ready_ids.pop_front();
            end
            default:
            begin
            end
        endcase
        r.head = (ready_ids.size() == 0) ? NO_ID : ready_ids[0];
        r.count = CNT_OUT_W'(ready_ids.size());
        r.peak = CNT_OUT_W'(peak_depth);
        return r;
    endfunction

    task automatic queue_word(kind_t op, logic [PID_W-1:0] pid);
        word_t w;
        w.op = op;
        w.pid = pid;
        pending_words.push_back(w);
    endtask

    // mostly a small pool so removes find matches and duplicates pile up
    function automatic logic [PID_W-1:0] pick_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            return PID_W'($urandom_range(0, 7));
        else if (sel < 9)
            return PID_W'($urandom_range(0, QDEPTH - 1));
        else
            return PID_W'($urandom_range(0, 127));
    endfunction

    task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // sender: bursts of words with random gaps, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_ENQ;
            proc_id <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_word(kind, proc_id));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    kind <= next_word.op;
                    proc_id <= next_word.pid;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern follows bits 9:8 of the cycle count, plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_cycle = 0;
            hold_left = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle == 1500 || rx_cycle == 4000)
                hold_left = HOLD_CYCLES;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[9:8])
                    2'd0: out_ready <= 1'b1;
                    2'd1: out_ready <= 1'($urandom_range(0, 1));
                    2'd2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (rx_cycle[2:0] != 3'd5);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: head_id %0d status %0d",
                       head_id, status);
                fail_count++;
            end
            else
            begin
                check_field("popped_id", expected_results[0].popped, popped_id);
                check_field("head_id", expected_results[0].head, head_id);
                check_field("entry_count", expected_results[0].count, entry_count);
                check_field("high_water", expected_results[0].peak, high_water);
                check_field("status", 7'(expected_results[0].st), 7'(status));
                void'(expected_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int mode;
        int len;
        int counted;
        kind_t op;
        logic [PID_W-1:0] pid;

        // directed: empty cases, id extremes, bad ids, duplicates, unused kind
        queue_word(KIND_POP, 7'd0);
        queue_word(KIND_REM, 7'd5);
        queue_word(KIND_ENQ, 7'd0);
        queue_word(KIND_ENQ, 7'd63);
        queue_word(KIND_ENQ, 7'd64);
        queue_word(KIND_ENQ, 7'd127);
        queue_word(KIND_REM, 7'd127);
        queue_word(KIND_REM, 7'd64);
        queue_word(KIND_ENQ, 7'd63);
        queue_word(KIND_ENQ, 7'd21);
        queue_word(KIND_REM, 7'd63);
        queue_word(KIND_NOP, 7'd42);
        queue_word(KIND_NOP, 7'd127);
        queue_word(KIND_REM, 7'd9);
        queue_word(KIND_ENQ, 7'd42);
        queue_word(KIND_ENQ, 7'd6);
        queue_word(KIND_REM, 7'd6);
        queue_word(KIND_REM, 7'd0);
        queue_word(KIND_POP, 7'd0);
        queue_word(KIND_POP, 7'd127);
        queue_word(KIND_POP, 7'd0);
        queue_word(KIND_POP, 7'd0);
        queue_word(KIND_POP, 7'd0);

        // random phases: fill to full, drain to empty, churn and noise
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            mode = $urandom_range(0, 3);
            len = (mode == 0) ? $urandom_range(60, 90) : $urandom_range(20, 80);
            repeat (len)
            begin
                pid = pick_id();
                case (mode)
                    0: op = ($urandom_range(0, 9) == 0) ? kind_t'($urandom_range(0, 3))
                                                        : KIND_ENQ;
                    1: op = ($urandom_range(0, 9) < 7) ? KIND_POP : KIND_REM;
                    2:
                    begin
                        op = kind_t'($urandom_range(0, 3));
                        pid = PID_W'($urandom_range(0, 127));
                    end
                    default: op = ($urandom_range(0, 1) == 0) ? KIND_ENQ : KIND_REM;
                endcase
                queue_word(op, pid);
                counted++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
